// ===== hw/rtl/sorted_unique_set_with_rank_assert.svh =====
// assertion macros for the sorted unique set with rank
// used by the checker module; needs clock and reset in the including scope
`ifndef SORTED_UNIQUE_SET_WITH_RANK_ASSERT_SVH
`define SORTED_UNIQUE_SET_WITH_RANK_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SUS_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("sus assertion failed");

// condition holds in the cycle after the trigger
`define SUS_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("sus assertion failed");

`endif

// ===== hw/rtl/sus_pkg.sv =====
// shared types and constants of the sorted unique set with rank
// no dependencies
package sus_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int KEY_BITS_DEF = 32;
   localparam int REQ_KEY_W    = 32;
   localparam int RSP_RANK_W   = 8;
   localparam int RSP_OCC_W    = 9;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [REQ_KEY_W-1:0]   key;
   } req_type;

   typedef struct packed {
      logic                   hit;
      logic [RSP_RANK_W-1:0]  rank;
      logic                   overflow;
      logic [RSP_OCC_W-1:0]   occupancy;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_EXEC
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      logic        cmp_en;
      cell_op_type op;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/sorted_unique_set_with_rank.sv =====
// sorted unique set with rank: a chain of compare-and-shift cells, one key per cell
// a request is captured on acceptance, compared in the compare state and shifted in the
// exec state, which registers its result strobe; a new request may be accepted during the
// shift pass, busy is high only in the compare state, the receiver cannot stall
// reset: synchronous, empties the set and clears the controller and result strobe
module sorted_unique_set_with_rank #(
   parameter int CAPACITY = sus_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = sus_pkg::KEY_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sus_pkg::req_type req_data,
   output logic             rsp_valid,
   output sus_pkg::rsp_type rsp_data
);
   import sus_pkg::*;

   // only the low KW key bits, at most 32, ever reach the set
   localparam int KW = (KEY_BITS < REQ_KEY_W) ? KEY_BITS : REQ_KEY_W;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_V = CW'(1);

   // controller
   state_type     state_ff, state_in;
   logic          accept;
   logic          exec;
   cell_ctl_type  ctl;

   // request hold
   kind_type      kind_ff, kind_in;
   logic [KW-1:0] key_ff, key_in;

   // set size
   logic [CW-1:0] count_ff, count_in;

   // result register
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // chain wiring
   logic [KW-1:0] entry_w [CAPACITY];
   logic [CAPACITY-1:0] lt_w;
   logic [CAPACITY-1:0] eq_w;
   logic [CAPACITY-1:0] pos_w;

   logic [RW-1:0] rank_w;
   logic          present_w;
   logic          full_w;
   logic [RW+RSP_RANK_W-1:0] rank_ext;
   logic [CW+RSP_OCC_W-1:0]  occ_ext;

   assign accept = start & ~busy;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // a new request may enter while the shift pass finishes
            state_in = start ? ST_CMP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // controller outputs
   always_comb begin
      busy = 1'b0;
      exec = 1'b0;
      case (state_ff)
         ST_CMP:  busy = 1'b1;
         ST_EXEC: exec = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture request
   always_comb begin
      kind_in = kind_ff;
      key_in  = key_ff;
      if (accept) begin
         kind_in = req_data.kind;
         key_in  = req_data.key[KW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      key_ff  <= key_in;
   end

   // the chain of cells
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [KW-1:0] left_e;
         logic          left_l;
         logic [KW-1:0] right_e;

         if (gi == 0) begin : g_first
            // nothing sits left of slot zero, so it counts as below the key
            assign left_e = key_ff;
            assign left_l = 1'b1;
         end else begin : g_mid
            assign left_e = entry_w[gi-1];
            assign left_l = lt_w[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign right_e = entry_w[gi];
         end else begin : g_inner
            assign right_e = entry_w[gi+1];
         end

         sus_cell #(
            .KW  (KW),
            .CW  (CW),
            .IDX (gi)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .key         (key_ff),
            .count       (count_ff),
            .left_entry  (left_e),
            .left_lt     (left_l),
            .right_entry (right_e),
            .entry       (entry_w[gi]),
            .lt          (lt_w[gi]),
            .eq          (eq_w[gi]),
            .at_pos      (pos_w[gi])
         );
      end
   endgenerate

   sus_rank_enc #(
      .N  (CAPACITY),
      .RW (RW)
   ) u_rank_enc (
      .pos_onehot (pos_w),
      .eq_flags   (eq_w),
      .rank       (rank_w),
      .present    (present_w)
   );

   assign full_w   = count_ff == CAP_V;
   assign rank_ext = {{RSP_RANK_W{1'b0}}, rank_w};

   // compare enable, then in the shift pass: the operation, the new size and the result
   always_comb begin
      ctl.cmp_en    = busy;
      ctl.op        = CELL_HOLD;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      if (exec) begin
         rsp_valid_in    = 1'b1;
         rsp_in.hit      = 1'b0;
         rsp_in.rank     = '0;
         rsp_in.overflow = 1'b0;
         case (kind_ff)
            KIND_INSERT: begin
               if (!present_w) begin
                  if (full_w) begin
                     // set is full, the key is dropped
                     rsp_in.overflow = 1'b1;
                  end else begin
                     ctl.op      = CELL_INSERT;
                     count_in    = count_ff + ONE_V;
                     rsp_in.hit  = 1'b1;
                     rsp_in.rank = rank_ext[RSP_RANK_W-1:0];
                  end
               end
            end
            KIND_REMOVE: begin
               if (present_w) begin
                  ctl.op      = CELL_REMOVE;
                  count_in    = count_ff - ONE_V;
                  rsp_in.hit  = 1'b1;
                  rsp_in.rank = rank_ext[RSP_RANK_W-1:0];
               end
            end
            KIND_LOOKUP: begin
               if (present_w) begin
                  rsp_in.hit  = 1'b1;
                  rsp_in.rank = rank_ext[RSP_RANK_W-1:0];
               end
            end
            KIND_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
      occ_ext          = {{RSP_OCC_W{1'b0}}, count_in};
      rsp_in.occupancy = exec ? occ_ext[RSP_OCC_W-1:0] : rsp_ff.occupancy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/sus_cell.sv =====
// one slot of the sorted chain: holds a key, compares it, shifts with its neighbors
// depends on sus_pkg
module sus_cell #(
   parameter int KW  = 32,
   parameter int CW  = 9,
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  sus_pkg::cell_ctl_type ctl,
   input  logic [KW-1:0]         key,
   input  logic [CW-1:0]         count,
   input  logic [KW-1:0]         left_entry,
   input  logic                  left_lt,
   input  logic [KW-1:0]         right_entry,
   output logic [KW-1:0]         entry,
   output logic                  lt,
   output logic                  eq,
   output logic                  at_pos
);
   import sus_pkg::*;

   localparam logic [CW-1:0] IDX_V = CW'(IDX);

   logic [KW-1:0] entry_ff;
   logic          lt_ff;
   logic          eq_ff;
   logic          occupied;

   assign occupied = IDX_V < count;
   // first slot not below the key
   assign at_pos   = left_lt & ~lt_ff;

   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         lt_ff <= occupied && (entry_ff < key);
         eq_ff <= occupied && (entry_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         CELL_INSERT: begin
            if (!lt_ff) begin
               entry_ff <= at_pos ? key : left_entry;
            end
         end
         CELL_REMOVE: begin
            if (!lt_ff) begin
               entry_ff <= right_entry;
            end
         end
         default: begin
         end
      endcase
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// ===== hw/rtl/sus_rank_enc.sv =====
// turns the chain's position marker into a binary rank and a presence flag
// depends on sus_pkg
module sus_rank_enc #(
   parameter int N  = 256,
   parameter int RW = 8
) (
   input  logic [N-1:0]  pos_onehot,
   input  logic [N-1:0]  eq_flags,
   output logic [RW-1:0] rank,
   output logic          present
);
   import sus_pkg::*;

   always_comb begin
      rank = '0;
      for (int i = 0; i < N; i++) begin
         if (pos_onehot[i]) begin
            rank = rank | RW'(i);
         end
      end
   end

   assign present = |eq_flags;

endmodule

// ===== hw/rtl/sus_checker.sv =====
// port-level checks of the sorted unique set with rank, bound to the top level
// depends on sus_pkg and sorted_unique_set_with_rank_assert.svh
`include "sorted_unique_set_with_rank_assert.svh"

module sus_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic             rsp_valid,
   input  sus_pkg::rsp_type rsp_data
);
   import sus_pkg::*;

   // an accepted request blocks for exactly its compare cycle
   `SUS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `SUS_ASSERT_NEXT(a_busy_short, busy, !busy)
   // every accepted request gets its result after its compare and shift states
   `SUS_ASSERT_NOW(a_result_due, start && !busy, ##3 rsp_valid)
   // a success never reports a dropped insert
   `SUS_ASSERT_NOW(a_hit_no_ovf, rsp_valid && rsp_data.hit, !rsp_data.overflow)

endmodule

bind sorted_unique_set_with_rank sus_checker u_sus_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
